/* src/bsfe_pkg.sv */
package bsfe_pkg;

  localparam int unsigned ByteW         = 8;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned SlotN         = 5;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_CODE  = 2'd0,
    CFG_ESCAPE_CODE = 2'd1,
    CFG_START_SUBST = 2'd2,
    CFG_ESCAPE_SUBST = 2'd3
  } cfg_idx_e;

  // Output slots of one request, in emission order
  localparam int unsigned SlotStart = 0;
  localparam int unsigned SlotEsc1  = 1;
  localparam int unsigned SlotEsc2  = 2;
  localparam int unsigned SlotData  = 3;
  localparam int unsigned SlotCsum  = 4;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_first;
    logic             frame_last;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             frame_end;
  } out_item_t;

  typedef struct packed {
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] escape_code;
    logic [ByteW-1:0] start_substitute;
    logic [ByteW-1:0] escape_substitute;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [SlotN-1:0] slots;
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] esc_byte;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] csum;
  } cmd_t;

endpackage

/* src/bsfe_front.sv */
module bsfe_front
  import bsfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  in_item_t item_i,
  output cmd_t     cmd_o
);

  logic [ByteW-1:0] csum_q, csum_d;
  logic             start_hit, esc_hit;
  logic [ByteW-1:0] sub_byte, final_byte, base;

  always_comb begin
    start_hit  = (item_i.data_byte == cfg_i.start_code);
    sub_byte   = start_hit ? cfg_i.start_substitute : item_i.data_byte;
    // second check sees the byte as it stands after the first
    esc_hit    = (sub_byte == cfg_i.escape_code);
    final_byte = esc_hit ? cfg_i.escape_substitute : sub_byte;
    base       = item_i.frame_first ? '0 : csum_q;
    csum_d     = base ^ (start_hit ? cfg_i.start_code : '0)
                      ^ (esc_hit ? cfg_i.escape_code : '0) ^ final_byte;

    cmd_o.slots            = '0;
    cmd_o.slots[SlotStart] = item_i.frame_first;
    cmd_o.slots[SlotEsc1]  = start_hit;
    cmd_o.slots[SlotEsc2]  = esc_hit;
    cmd_o.slots[SlotData]  = 1'b1;
    cmd_o.slots[SlotCsum]  = item_i.frame_last;
    cmd_o.start_byte       = cfg_i.start_code;
    cmd_o.esc_byte         = cfg_i.escape_code;
    cmd_o.data_byte        = final_byte;
    cmd_o.csum             = csum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_q <= '0;
    end else if (accept_i) begin
      csum_q <= csum_d;
    end
  end

endmodule

/* src/bsfe_queue.sv */
module bsfe_queue
  import bsfe_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
)(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == Full);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("queue pushed while full");

endmodule

/* src/bsfe_back.sv */
module bsfe_back
  import bsfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t             cur_q;
  logic [SlotN-1:0] slots_q, slots_d, low_bit;
  logic             load_ok, emit;
  out_item_t        out_q, out_d;
  logic             out_valid_q;
  logic [ByteW-1:0] sel_byte;

  always_comb begin
    load_ok = !out_valid_q || !out_stall_i;
    emit    = load_ok && (slots_q != '0);
    low_bit = slots_q & (~slots_q + 1'b1);

    if (slots_q[SlotStart])     sel_byte = cur_q.start_byte;
    else if (slots_q[SlotEsc1]) sel_byte = cur_q.esc_byte;
    else if (slots_q[SlotEsc2]) sel_byte = cur_q.esc_byte;
    else if (slots_q[SlotData]) sel_byte = cur_q.data_byte;
    else                        sel_byte = cur_q.csum;

    slots_d = emit ? (slots_q & ~low_bit) : slots_q;

    out_d.out_byte  = sel_byte;
    out_d.run_last  = (slots_d == '0);
    out_d.frame_end = (low_bit[SlotCsum]);

    // take the next request as soon as the current one has nothing left
    q_pop_o = q_valid_i && (slots_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slots_q <= q_pop_o ? q_data_i.slots : slots_d;
      if (load_ok) begin
        out_valid_q <= emit;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_data_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !slots_q[SlotData] |-> (slots_q[SlotEsc2:SlotStart] == '0))
    else $error("escape or start slot pending after data byte");

  a_csum_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.frame_end) |-> out_q.run_last)
    else $error("checksum byte not last of its run");

endmodule

/* src/byte_stuffing_frame_encoder.sv */
// Byte-stuffing frame encoder with an 8-bit XOR checksum.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one raw frame byte per
// request, flagged frame_first and frame_last. Output channel (out_valid_o /
// out_stall_i / out_data_o): one encoded byte per request; run_last marks the
// final byte caused by an input and frame_end marks the checksum byte.
// Each input yields 1 to 5 output bytes: start code on frame_first, escape
// pairs for start and escape codes, the byte, and the checksum on frame_last.
//
// When idle, the first byte of an input passes from the queue through the
// request registers of the back sequencer into its output register.
// Throughput: one output byte per cycle while the receiver does not stall,
// set by the single output register in the back sequencer. The front
// classifies and updates the checksum in the cycle of acceptance and parks
// the request in a short queue, so inputs keep flowing while the back drains
// earlier ones.
// Reset clears the checksum, the queue and the output valid flag and loads the
// default codes (192, 219, 220, 221). When the receiver stalls, hold the
// output byte; the queue then fills and in_stall_o rises once it is full.
// Write configuration only while the block is idle.
module byte_stuffing_frame_encoder
  import bsfe_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
)(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_data_i
);

  cfg_t cfg_q;
  logic in_accept, q_full, q_valid, q_pop;
  cmd_t cmd_in, cmd_out;

  // Configuration registers: plain writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code        <= 8'd192;
      cfg_q.escape_code       <= 8'd219;
      cfg_q.start_substitute  <= 8'd220;
      cfg_q.escape_substitute <= 8'd221;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_CODE:   cfg_q.start_code        <= cfg_data_i;
        CFG_ESCAPE_CODE:  cfg_q.escape_code       <= cfg_data_i;
        CFG_START_SUBST:  cfg_q.start_substitute  <= cfg_data_i;
        CFG_ESCAPE_SUBST: cfg_q.escape_substitute <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall input only when the queue has no room
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  bsfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_accept),
    .item_i   (in_data_i),
    .cmd_o    (cmd_in)
  );

  bsfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (cmd_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (cmd_out)
  );

  bsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (cmd_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
